// File: rtl/core/slot_table_free_list_chain_macros.svh
// Assertion macros shared by the slot table RTL.
// Standalone header; the modules that check their own logic include it.
`ifndef SLOT_TABLE_FREE_LIST_CHAIN_MACROS_SVH
`define SLOT_TABLE_FREE_LIST_CHAIN_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every rising edge outside reset.
`define STFLC_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
		else $error("slot table check failed");
// Condition that must never be seen at a rising edge outside reset.
`define STFLC_NEVER(label, clk, rst_n, cond) \
	`STFLC_ASSERT(label, clk, rst_n, !(cond))
`else
`define STFLC_ASSERT(label, clk, rst_n, prop)
`define STFLC_NEVER(label, clk, rst_n, cond)
`endif
`endif

// File: rtl/core/stflc_pkg.sv
// Shared types and codes of the slot table with free list and chain.
// No dependencies; every other file of the block but the macro header uses it.
`timescale 1ns / 1ps
package stflc_pkg;

	// Action codes of a request beat.
	localparam logic [1:0] ACT_ADD    = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;
	localparam logic [1:0] ACT_READ   = 2'd2;
	localparam logic [1:0] ACT_NOP    = 2'd3;

	// Status codes of a result beat.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NOT_USED = 2'd2;

	// Request beat.
	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] marker_handle;
		logic [5:0]  slot_index;
	} req_t;

	// Result beat.
	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  slot_out;
		logic [15:0] handle_out;
		logic [5:0]  next_slot;
		logic        next_valid;
		logic [5:0]  prev_slot;
		logic        prev_valid;
		logic [5:0]  head_slot;
		logic        head_valid;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic lookup;
		logic exec;
		logic link;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_link;
	} stat_t;

endpackage

// File: rtl/core/stflc_ctrl.sv
// Sequencer of the slot table: accepts a beat, steps the datapath, strobes the result.
// Depends on stflc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "slot_table_free_list_chain_macros.svh"
module stflc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	output logic             done,
	output stflc_pkg::cmd_t  cmd,
	input  stflc_pkg::stat_t stat
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_LINK = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nx;
	logic       done_q;
	logic       finish;

	// Commands follow the state directly.
	assign busy       = (state_q != S_IDLE);
	assign cmd.lookup = start && (state_q == S_IDLE);
	assign cmd.exec   = (state_q == S_EXEC);
	assign cmd.link   = (state_q == S_LINK);
	assign finish     = (cmd.exec && !stat.need_link) || cmd.link;
	assign done       = done_q;

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_nx = S_EXEC;
			end
			S_EXEC: begin
				state_nx = stat.need_link ? S_LINK : S_IDLE;
			end
			S_LINK: begin
				state_nx = S_IDLE;
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// State and result strobe registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			done_q  <= finish;
		end
	end

	`STFLC_ASSERT(a_done_single, clk, arst_n, done_q |=> !done_q)
	`STFLC_ASSERT(a_accept_busy, clk, arst_n, (start && !busy) |=> busy)
	`STFLC_ASSERT(a_idle_strobe, clk, arst_n, $fell(busy) |-> done_q)

endmodule

// File: rtl/core/stflc_dpath.sv
// Datapath of the slot table: slot memories, head, free list top and result register.
// Depends on stflc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "slot_table_free_list_chain_macros.svh"
module stflc_dpath #(
	parameter int CAPACITY    = 64,
	parameter int HANDLE_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  stflc_pkg::req_t  req,
	input  stflc_pkg::cmd_t  cmd,
	output stflc_pkg::stat_t stat,
	output stflc_pkg::rsp_t  rsp
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int LW = AW + 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = ((AW > 6) ? AW : 6) + 1;
	localparam int HW = HANDLE_BITS;

	// Slot memories; a link is a valid bit over a slot number.
	logic [HW-1:0] handle_mem [CAPACITY];
	logic [LW-1:0] next_mem   [CAPACITY];
	logic [LW-1:0] prev_mem   [CAPACITY];
	logic [LW-1:0] free_mem   [CAPACITY];
	logic          use_mem    [CAPACITY];

	logic [HW-1:0] handle_rd_q;
	logic [LW-1:0] next_rd_q;
	logic [LW-1:0] prev_rd_q;
	logic [LW-1:0] free_rd_q;
	logic          use_rd_q;

	logic [1:0]    act_q;
	logic [HW-1:0] hdl_q;
	logic [5:0]    slot_q;

	logic [LW-1:0] head_q;
	logic [LW-1:0] freed_top_q;
	logic [CW-1:0] untouched_q;
	logic [AW-1:0] lnk_head_q;
	logic [AW-1:0] lnk_slot_q;
	stflc_pkg::rsp_t res_q;

	logic [AW-1:0] rd_addr;
	logic [AW-1:0] slot_a;
	logic          is_add;
	logic          is_rem;
	logic          is_rd;
	logic          range_ok;
	logic          touched;
	logic          live;
	logic          pop_free;
	logic          add_ok;
	logic          rem_ok;
	logic          rd_ok;
	logic [AW-1:0] new_slot;
	logic [LW-1:0] head_nx;
	stflc_pkg::rsp_t res_nx;

	logic          h_we;
	logic          n_we;
	logic [AW-1:0] n_wa;
	logic [LW-1:0] n_wd;
	logic          p_we;
	logic [AW-1:0] p_wa;
	logic [LW-1:0] p_wd;
	logic          f_we;
	logic          u_we;
	logic [AW-1:0] u_wa;

	assign rd_addr = AW'(req.slot_index);
	assign slot_a  = AW'(slot_q);

	// Decode of the held request and the lookup results.
	assign is_add   = (act_q == stflc_pkg::ACT_ADD);
	assign is_rem   = (act_q == stflc_pkg::ACT_REMOVE);
	assign is_rd    = (act_q == stflc_pkg::ACT_READ);
	assign range_ok = IW'(slot_q) < IW'(CAPACITY);
	// Slots below the untouched count were never handed out, so their use bit is stale.
	assign touched  = IW'(slot_q) >= IW'(untouched_q);
	assign live     = range_ok && touched && use_rd_q;
	assign pop_free = freed_top_q[AW];
	assign add_ok   = is_add && (pop_free || (untouched_q != '0));
	assign rem_ok   = is_rem && live;
	assign rd_ok    = is_rd && live;
	assign new_slot = pop_free ? freed_top_q[AW-1:0] : AW'(untouched_q - CW'(1));

	// Head after this step.
	always_comb begin
		head_nx = head_q;
		if (add_ok) head_nx = {1'b1, new_slot};
		else if (rem_ok && !prev_rd_q[AW]) head_nx = next_rd_q;
	end

	assign stat.need_link = cmd.exec && add_ok && head_q[AW];

	// Memory write ports.
	always_comb begin
		h_we = cmd.exec && add_ok;
		n_we = 1'b0;
		n_wa = new_slot;
		n_wd = head_q;
		p_we = 1'b0;
		p_wa = new_slot;
		p_wd = '0;
		f_we = cmd.exec && rem_ok;
		u_we = 1'b0;
		u_wa = new_slot;
		if (cmd.exec && add_ok) begin
			n_we = 1'b1;
			p_we = 1'b1;
			u_we = 1'b1;
		end else if (cmd.exec && rem_ok) begin
			n_we = prev_rd_q[AW];
			n_wa = prev_rd_q[AW-1:0];
			n_wd = next_rd_q;
			p_we = next_rd_q[AW];
			p_wa = next_rd_q[AW-1:0];
			p_wd = prev_rd_q;
			u_we = 1'b1;
			u_wa = slot_a;
		end else if (cmd.link) begin
			p_we = 1'b1;
			p_wa = lnk_head_q;
			p_wd = {1'b1, lnk_slot_q};
		end
	end

	// Memories: one write and one registered read each.
	always_ff @(posedge clk) begin
		if (h_we) handle_mem[new_slot] <= hdl_q;
		if (cmd.lookup) handle_rd_q <= handle_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (n_we) next_mem[n_wa] <= n_wd;
		if (cmd.lookup) next_rd_q <= next_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (p_we) prev_mem[p_wa] <= p_wd;
		if (cmd.lookup) prev_rd_q <= prev_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (f_we) free_mem[slot_a] <= freed_top_q;
		if (cmd.lookup) free_rd_q <= free_mem[freed_top_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (u_we) use_mem[u_wa] <= (cmd.exec && add_ok);
		if (cmd.lookup) use_rd_q <= use_mem[rd_addr];
	end

	// Request hold and link bookkeeping registers.
	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			act_q  <= req.action;
			hdl_q  <= HW'(req.marker_handle);
			slot_q <= req.slot_index;
		end
		if (cmd.exec) begin
			lnk_head_q <= head_q[AW-1:0];
			lnk_slot_q <= new_slot;
			res_q      <= res_nx;
		end
	end

	// Chain head, free list top and untouched count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			freed_top_q <= '0;
			untouched_q <= CW'(CAPACITY);
		end else if (cmd.exec) begin
			head_q <= head_nx;
			if (add_ok && pop_free) freed_top_q <= free_rd_q;
			else if (rem_ok) freed_top_q <= {1'b1, slot_a};
			if (add_ok && !pop_free) untouched_q <= untouched_q - CW'(1);
		end
	end

	// Result beat of this step.
	always_comb begin
		res_nx            = '0;
		res_nx.status     = stflc_pkg::ST_OK;
		res_nx.slot_out   = slot_q;
		if (is_add) begin
			res_nx.slot_out = add_ok ? 6'(new_slot) : 6'd0;
			if (!add_ok) res_nx.status = stflc_pkg::ST_FULL;
		end else if ((is_rem || is_rd) && !live) begin
			res_nx.status = stflc_pkg::ST_NOT_USED;
		end
		if (rd_ok) begin
			res_nx.handle_out = 16'(handle_rd_q);
			if (next_rd_q[AW]) begin
				res_nx.next_slot  = 6'(next_rd_q[AW-1:0]);
				res_nx.next_valid = 1'b1;
			end
			if (prev_rd_q[AW]) begin
				res_nx.prev_slot  = 6'(prev_rd_q[AW-1:0]);
				res_nx.prev_valid = 1'b1;
			end
		end
		if (head_nx[AW]) begin
			res_nx.head_slot  = 6'(head_nx[AW-1:0]);
			res_nx.head_valid = 1'b1;
		end
	end

	assign rsp = res_q;

	`STFLC_NEVER(a_count_bound, clk, arst_n, untouched_q > CW'(CAPACITY))
	`STFLC_ASSERT(a_add_head, clk, arst_n, (cmd.exec && add_ok) |=> head_q[AW])
	`STFLC_ASSERT(a_rem_free, clk, arst_n, (cmd.exec && rem_ok) |=> freed_top_q[AW])

endmodule

// File: rtl/core/slot_table_free_list_chain.sv
// Top level of the slot table with free list and doubly linked chain.
// Depends on stflc_pkg, stflc_ctrl and stflc_dpath.
`timescale 1ns / 1ps
// A request beat is taken on a rising edge with start high and busy low; the
// slot memories are read on that same edge. Remove, read, no-operation and an
// add that finds the table full keep busy high through the exec state only,
// as does an add that finds the chain empty; a successful add onto a non-empty
// chain also passes through the link state, which writes the back link of the
// old head through the single write port of the prev-link memory. The result beat
// appears on rsp with done high for exactly one cycle, the first cycle after
// busy drops, and a new request may be taken in that same cycle. The receiver
// cannot hold a result off, so it must take rsp whenever done is high. Reset
// needs no clearing pass: slots never handed out are told apart by the
// untouched count.
module slot_table_free_list_chain #(
	parameter int CAPACITY    = 64,
	parameter int HANDLE_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  stflc_pkg::req_t req,
	output logic            done,
	output stflc_pkg::rsp_t rsp
);

	stflc_pkg::cmd_t  cmd;
	stflc_pkg::stat_t stat;

	// Sequencer.
	stflc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.stat   (stat)
	);

	// Memories and state registers.
	stflc_dpath #(
		.CAPACITY    (CAPACITY),
		.HANDLE_BITS (HANDLE_BITS)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule

// File: verif/slot_table_free_list_chain_test.sv
// Self-checking testbench for the slot table with free list and linked chain.
// Depends on stflc_pkg and the slot_table_free_list_chain RTL; needs no other file.
`timescale 1ns / 1ps
module slot_table_free_list_chain_test;

	localparam int SLOTS      = 64;
	localparam int ITEM_TOTAL = 1050;
	localparam int QUIET_FROM = ITEM_TOTAL - 150;
	localparam int WATCHDOG   = 500;

	// A chain or free-list link: valid flag and slot number.
	typedef struct packed {
		logic       v;
		logic [5:0] idx;
	} link_t;

	// Tracks the table contents and holds the result beats still owed by the block.
	class slot_chain_tracker;
		logic [15:0]     handles [SLOTS];
		link_t           nxt [SLOTS];
		link_t           prv [SLOTS];
		link_t           free_nxt [SLOTS];
		bit              used [SLOTS];
		link_t           head;
		link_t           free_top;
		int              fresh_cnt;
		stflc_pkg::rsp_t owed_rsp_q [$];
		int              bad;
		int              beats;

		function new();
			foreach (used[i]) used[i] = 1'b0;
			head      = '0;
			free_top  = '0;
			fresh_cnt = SLOTS;
			bad       = 0;
			beats     = 0;
		endfunction

		// Apply one accepted request beat and queue the result it must produce.
		function void take_request(stflc_pkg::req_t r);
			stflc_pkg::rsp_t e;
			logic [5:0]      s;
			link_t           p;
			link_t           n;
			bit              got;
			e = '0;
			e.slot_out = r.slot_index;
			s = r.slot_index;
			case (r.action)
			stflc_pkg::ACT_ADD: begin
				got = 1'b1;
				if (free_top.v) begin
					s = free_top.idx;
					free_top = free_nxt[s];
				end else if (fresh_cnt > 0) begin
					fresh_cnt--;
					s = 6'(fresh_cnt);
				end else begin
					got = 1'b0;
				end
				if (!got) begin
					e.status   = stflc_pkg::ST_FULL;
					e.slot_out = '0;
				end else begin
					handles[s] = r.marker_handle;
					nxt[s] = head;
					prv[s] = '0;
					used[s] = 1'b1;
					if (head.v)
						prv[head.idx] = '{1'b1, s};
					head = '{1'b1, s};
					e.status   = stflc_pkg::ST_OK;
					e.slot_out = s;
				end
			end
			stflc_pkg::ACT_NOP: begin
				e.status = stflc_pkg::ST_OK;
			end
			default: begin
				if (!used[s]) begin
					e.status = stflc_pkg::ST_NOT_USED;
				end else if (r.action == stflc_pkg::ACT_REMOVE) begin
					// Unlink from the chain, then push onto the free list.
					p = prv[s];
					n = nxt[s];
					if (p.v)
						nxt[p.idx] = n;
					else
						head = n;
					if (n.v)
						prv[n.idx] = p;
					used[s] = 1'b0;
					free_nxt[s] = free_top;
					free_top = '{1'b1, s};
					e.status = stflc_pkg::ST_OK;
				end else begin
					e.status     = stflc_pkg::ST_OK;
					e.handle_out = handles[s];
					e.next_valid = nxt[s].v;
					e.next_slot  = nxt[s].v ? nxt[s].idx : 6'd0;
					e.prev_valid = prv[s].v;
					e.prev_slot  = prv[s].v ? prv[s].idx : 6'd0;
				end
			end
			endcase
			e.head_valid = head.v;
			e.head_slot  = head.v ? head.idx : 6'd0;
			owed_rsp_q.push_back(e);
		endfunction

		// Four-state compare, so an unknown result bit counts as a mismatch.
		function void cmp_field(string nm, logic [15:0] want, logic [15:0] got);
			if (want !== got) begin
				bad++;
				if (bad <= 10)
					$display("result beat %0d: %s expected %0h, actual %0h",
						beats, nm, want, got);
			end
		endfunction

		// Compare one result beat against the oldest owed result.
		function void check_rsp(stflc_pkg::rsp_t a);
			stflc_pkg::rsp_t e;
			beats++;
			if (owed_rsp_q.size() == 0) begin
				bad++;
				if (bad <= 10)
					$display("result beat %0d arrived with no request pending", beats);
				return;
			end
			e = owed_rsp_q.pop_front();
			cmp_field("status", 16'(e.status), 16'(a.status));
			cmp_field("slot_out", 16'(e.slot_out), 16'(a.slot_out));
			cmp_field("handle_out", e.handle_out, a.handle_out);
			cmp_field("next_slot", 16'(e.next_slot), 16'(a.next_slot));
			cmp_field("next_valid", 16'(e.next_valid), 16'(a.next_valid));
			cmp_field("prev_slot", 16'(e.prev_slot), 16'(a.prev_slot));
			cmp_field("prev_valid", 16'(e.prev_valid), 16'(a.prev_valid));
			cmp_field("head_slot", 16'(e.head_slot), 16'(a.head_slot));
			cmp_field("head_valid", 16'(e.head_valid), 16'(a.head_valid));
		endfunction

		function int pending();
			return owed_rsp_q.size();
		endfunction

		function bit table_full();
			return !free_top.v && fresh_cnt == 0;
		endfunction

		function bit chain_empty();
			return !head.v;
		endfunction

		// A random occupied slot, or -1 when the chain is empty.
		function int pick_used();
			int live [$];
			foreach (used[i])
				if (used[i])
					live.push_back(i);
			if (live.size() == 0)
				return -1;
			return live[$urandom_range(0, live.size() - 1)];
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	stflc_pkg::req_t req;
	logic done;
	stflc_pkg::rsp_t rsp;

	slot_chain_tracker sb = new();
	int items = 0;
	int gap_pct = 0;
	int idle_cycles = 0;

	slot_table_free_list_chain u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	always #1 clk = ~clk;

	// Result checking and the no-progress watchdog.
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_rsp(rsp);
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Present one request beat and hold it until the block takes it.
	task automatic push_request(input stflc_pkg::req_t r);
		req <= r;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		sb.take_request(r);
		items++;
		if (items < QUIET_FROM && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	task automatic send(input logic [1:0] act, input logic [15:0] hnd, input logic [5:0] slot);
		stflc_pkg::req_t r;
		r.action = act;
		r.marker_handle = hnd;
		r.slot_index = slot;
		push_request(r);
	endtask

	// Hold the sender off until every owed result has come back.
	task automatic drain_wait();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// One random beat; remove and read mostly target occupied slots.
	task automatic random_item(input int add_w, input int rem_w);
		logic [1:0] act;
		int         pick;
		int         roll;
		logic [5:0] slot;
		roll = $urandom_range(0, 99);
		if (roll < add_w)
			act = stflc_pkg::ACT_ADD;
		else if (roll < add_w + rem_w)
			act = stflc_pkg::ACT_REMOVE;
		else if (roll < 97)
			act = stflc_pkg::ACT_READ;
		else
			act = stflc_pkg::ACT_NOP;
		slot = 6'($urandom_range(0, SLOTS - 1));
		pick = sb.pick_used();
		if (act != stflc_pkg::ACT_ADD && pick >= 0 && $urandom_range(0, 99) < 88)
			slot = 6'(pick);
		send(act, 16'($urandom_range(0, 65535)), slot);
	endtask

	initial begin
		int kind;
		int span;
		arst_n <= 1'b0;
		start <= 1'b0;
		req <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed beats: unused slots, handle extremes, chain middle, head and tail.
		gap_pct = 30;
		send(stflc_pkg::ACT_READ, 16'h0000, 6'd0);
		send(stflc_pkg::ACT_REMOVE, 16'hFFFF, 6'd63);
		send(stflc_pkg::ACT_NOP, 16'hFFFF, 6'd42);
		send(stflc_pkg::ACT_ADD, 16'h0000, 6'd0);
		send(stflc_pkg::ACT_ADD, 16'hFFFF, 6'd63);
		send(stflc_pkg::ACT_ADD, 16'h5A5A, 6'd21);
		send(stflc_pkg::ACT_READ, 16'h0000, 6'd63);
		send(stflc_pkg::ACT_READ, 16'h0000, 6'd62);
		send(stflc_pkg::ACT_READ, 16'hFFFF, 6'd61);
		send(stflc_pkg::ACT_REMOVE, 16'h0000, 6'd62);
		send(stflc_pkg::ACT_READ, 16'h0000, 6'd63);
		send(stflc_pkg::ACT_READ, 16'h0000, 6'd61);
		send(stflc_pkg::ACT_REMOVE, 16'h0000, 6'd62);
		send(stflc_pkg::ACT_ADD, 16'h1234, 6'd0);
		send(stflc_pkg::ACT_REMOVE, 16'h0000, 6'd61);
		send(stflc_pkg::ACT_REMOVE, 16'h0000, 6'd63);
		send(stflc_pkg::ACT_READ, 16'h0000, 6'd62);
		send(stflc_pkg::ACT_REMOVE, 16'h0000, 6'd62);
		send(stflc_pkg::ACT_READ, 16'h0000, 6'd62);
		send(stflc_pkg::ACT_NOP, 16'h0000, 6'd0);
		drain_wait();

		// Random phases: fill to full, drain to empty, or a mixed run.
		while (items < ITEM_TOTAL) begin
			kind = $urandom_range(0, 2);
			case ($urandom_range(0, 2))
			0: gap_pct = 0;
			1: gap_pct = 15;
			default: gap_pct = 50;
			endcase
			if (items < QUIET_FROM && $urandom_range(0, 3) == 0)
				drain_wait();
			case (kind)
			0: begin
				while (!sb.table_full() && items < ITEM_TOTAL)
					random_item(80, 5);
				repeat ($urandom_range(1, 4)) random_item(70, 10);
			end
			1: begin
				while (!sb.chain_empty() && items < ITEM_TOTAL)
					random_item(5, 80);
				repeat ($urandom_range(1, 4)) random_item(5, 60);
			end
			default: begin
				span = $urandom_range(20, 80);
				repeat (span) random_item(40, 30);
			end
			endcase
		end

		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.bad == 0 && sb.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
